// ===== sv/qau_pkg.sv =====
package qau_pkg;

  localparam int FracBits = 14;
  localparam int WordBits = 16;
  // product width of two words
  localparam int ProdBits = 2 * WordBits;
  // sums of up to four products plus the matrix "one" term
  localparam int AccBits = ProdBits + 4;
  // sum of four squares
  localparam int SqBits = ProdBits + 2;
  localparam int RootBits = SqBits / 2;
  // dividend: |c| << FracBits, doubled
  localparam int NumBits = WordBits + FracBits + 2;

  localparam logic [1:0] FUNC_PROD = 2'd0;
  localparam logic [1:0] FUNC_SCALE = 2'd1;
  localparam logic [1:0] FUNC_NORM = 2'd2;
  localparam logic [1:0] FUNC_MAT = 2'd3;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [AccBits-1:0] acc_t;

  // round half up of v / 2^sh, then clamp to the word range
  function automatic logic [WordBits:0] round_sat(input acc_t v, input int sh);
    acc_t r;
    acc_t hi;
    acc_t lo;
    logic f;
    begin
      r = (v + (acc_t'(1) <<< (sh - 1))) >>> sh;
      hi = acc_t'((64'sd1 <<< (WordBits - 1)) - 1);
      lo = -hi - acc_t'(1);
      f = 1'b0;
      if (r > hi) begin
        r = hi;
        f = 1'b1;
      end
      if (r < lo) begin
        r = lo;
        f = 1'b1;
      end
      round_sat = {f, r[WordBits-1:0]};
    end
  endfunction

endpackage

// ===== sv/qau_sqrt_stage.sv =====
// one step of the bit-pair square root, carried with its beat
// the partial root runs scaled by the current bit until the last step
module qau_sqrt_stage (
  input  logic [qau_pkg::SqBits-1:0] rem_in,
  input  logic [qau_pkg::SqBits-1:0] root_in,
  input  logic [qau_pkg::SqBits-1:0] bit_in,
  output logic [qau_pkg::SqBits-1:0] rem_out,
  output logic [qau_pkg::SqBits-1:0] root_out
);
  logic [qau_pkg::SqBits-1:0] trial;

  assign trial = root_in + bit_in;

  always_comb begin
    if (rem_in >= trial) begin
      rem_out = rem_in - trial;
      root_out = (root_in >> 1) + bit_in;
    end else begin
      rem_out = rem_in;
      root_out = root_in >> 1;
    end
  end
endmodule

// ===== sv/qau_div_stage.sv =====
// one restoring division step: shift in one dividend bit, subtract if it fits
module qau_div_stage (
  input  logic [qau_pkg::RootBits+1:0] rem_in,
  input  logic                         num_bit,
  input  logic [qau_pkg::RootBits+1:0] den,
  output logic [qau_pkg::RootBits+1:0] rem_out,
  output logic                         q_bit
);
  logic [qau_pkg::RootBits+2:0] sh;

  assign sh = {rem_in, num_bit};

  always_comb begin
    if (sh >= {1'b0, den}) begin
      rem_out = (qau_pkg::RootBits+2)'(sh - {1'b0, den});
      q_bit = 1'b1;
    end else begin
      rem_out = (qau_pkg::RootBits+2)'(sh);
      q_bit = 1'b0;
    end
  end
endmodule

// ===== sv/qau_norm_pipe.sv =====
// normalize path: squares, pipelined root (one bit pair per stage), then
// four pipelined dividers (one quotient bit per stage). All stages share
// the same advance enable so the path lines up with the product path.
module qau_norm_pipe (
  input  logic                      clk,
  input  logic                      adv,
  input  qau_pkg::word_t            c_in [4],
  output logic [qau_pkg::WordBits:0] res_out [4],
  output logic                      zero_out
);
  localparam int SqSteps = qau_pkg::RootBits;
  localparam int DivSteps = qau_pkg::NumBits;
  localparam int RB = qau_pkg::RootBits;

  logic [qau_pkg::SqBits-1:0] n2;
  logic [qau_pkg::SqBits-1:0] srem [SqSteps+1];
  logic [qau_pkg::SqBits-1:0] sroot [SqSteps+1];
  qau_pkg::word_t             sc [SqSteps+1][4];
  logic [qau_pkg::SqBits-1:0] srem_n [SqSteps];
  logic [qau_pkg::SqBits-1:0] sroot_n [SqSteps];

  // sum of squares
  always_comb begin
    n2 = '0;
    for (int i = 0; i < 4; i++) begin
      logic signed [qau_pkg::ProdBits-1:0] cw;
      cw = qau_pkg::ProdBits'(c_in[i]);
      n2 = n2 + qau_pkg::SqBits'($unsigned(cw * cw));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srem[0] <= n2;
      sroot[0] <= '0;
      sc[0] <= c_in;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    qau_sqrt_stage u_st (
      .rem_in  (srem[k]),
      .root_in (sroot[k]),
      .bit_in  (qau_pkg::SqBits'(1) << (qau_pkg::SqBits - 2 - 2 * k)),
      .rem_out (srem_n[k]),
      .root_out(sroot_n[k])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        srem[k+1] <= srem_n[k];
        sroot[k+1] <= sroot_n[k];
        sc[k+1] <= sc[k];
      end
    end
  end

  // divide: q = floor((2|c|<<F + L) / 2L), sign applied after, which for
  // negative c gives floor((2c<<F + L)/2L) via -(ceil) handling below
  logic [RB-1:0]             len;
  logic [RB+1:0]             den;
  logic                      zero;
  logic [qau_pkg::NumBits:0] numf [4];

  assign len = sroot[SqSteps][RB-1:0];
  assign den = {1'b0, len, 1'b0};
  assign zero = (len == '0);

  // for c>=0: num = 2c<<F + L ; for c<0: floor((-m+L)/2L) = -ceil((m-L)/2L)
  //   = -floor((m-L+2L-1)/2L) = -floor((m+L-1)/2L)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [qau_pkg::NumBits:0] m;
      m = (qau_pkg::NumBits+1)'($unsigned(
            sc[SqSteps][i][qau_pkg::WordBits-1] ? -32'(sc[SqSteps][i])
                                                : 32'(sc[SqSteps][i])))
          << (qau_pkg::FracBits + 1);
      if (sc[SqSteps][i][qau_pkg::WordBits-1])
        numf[i] = m + (qau_pkg::NumBits+1)'(len) - 1'b1;
      else
        numf[i] = m + (qau_pkg::NumBits+1)'(len);
    end
  end

  logic [RB+1:0]               drem [DivSteps+1][4];
  logic [qau_pkg::NumBits:0]   dnum [DivSteps+1][4];
  logic [DivSteps-1:0]         dq [DivSteps+1][4];
  logic                        dneg [DivSteps+1][4];
  logic [RB+1:0]               dden [DivSteps+1];
  logic                        dzero [DivSteps+1];
  logic [RB+1:0]               drem_n [DivSteps][4];
  logic                        dbit [DivSteps][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      dden[0] <= den;
      dzero[0] <= zero;
      for (int i = 0; i < 4; i++) begin
        drem[0][i] <= '0;
        dnum[0][i] <= numf[i];
        dq[0][i] <= '0;
        dneg[0][i] <= sc[SqSteps][i][qau_pkg::WordBits-1];
      end
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    for (genvar i = 0; i < 4; i++) begin : g_lane
      qau_div_stage u_dv (
        .rem_in (drem[k][i]),
        .num_bit(dnum[k][i][qau_pkg::NumBits - 1 - k]),
        .den    (dden[k]),
        .rem_out(drem_n[k][i]),
        .q_bit  (dbit[k][i])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dden[k+1] <= dden[k];
        dzero[k+1] <= dzero[k];
        for (int i = 0; i < 4; i++) begin
          drem[k+1][i] <= drem_n[k][i];
          dnum[k+1][i] <= dnum[k][i];
          dq[k+1][i] <= {dq[k][i][DivSteps-2:0], dbit[k][i]};
          dneg[k+1][i] <= dneg[k][i];
        end
      end
    end
  end

  // sign and clamp; a zero length forces the result to zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [DivSteps+1:0] v;
      logic f;
      v = $signed({2'b00, dq[DivSteps][i]});
      if (dneg[DivSteps][i]) v = -v;
      f = 1'b0;
      if (v > (DivSteps+2)'(2**(qau_pkg::WordBits-1) - 1)) begin
        v = (DivSteps+2)'(2**(qau_pkg::WordBits-1) - 1);
        f = 1'b1;
      end
      if (v < -(DivSteps+2)'(2**(qau_pkg::WordBits-1))) begin
        v = -(DivSteps+2)'(2**(qau_pkg::WordBits-1));
        f = 1'b1;
      end
      if (dzero[DivSteps]) begin
        v = '0;
        f = 1'b0;
      end
      res_out[i] = {f, v[qau_pkg::WordBits-1:0]};
    end
  end
  assign zero_out = dzero[DivSteps];
endmodule

// ===== sv/quaternion_arith_unit.sv =====
// Quaternion unit, signed Q2.14. One beat in, one beat out; a new beat can
// enter every cycle while the output is not stalled. The depth to the output
// register is set by the normalize path: one squaring stage, 17 root stages
// (one bit pair each), one divider set-up stage, 32 quotient stages (one bit
// each) and the output register. Product, scale and matrix results are
// delayed to match, so beats leave in order. ready drops whenever the
// output register holds an untaken beat; a stall freezes every stage.
module quaternion_arith_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     func,
  input  qau_pkg::word_t a_x, a_y, a_z, a_w,
  input  qau_pkg::word_t b_x, b_y, b_z, b_w,
  input  qau_pkg::word_t scale_factor,
  output logic           out_valid,
  input  logic           out_ready,
  output qau_pkg::word_t r0, r1, r2, r3, r4, r5, r6, r7, r8,
  output logic           fault
);
  localparam int NormLat = qau_pkg::RootBits + qau_pkg::NumBits + 2;
  localparam int Lat = NormLat;

  // global advance: whole pipe moves when the output slot is free or taken
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  qau_pkg::word_t ca [4];
  assign ca[0] = a_x;
  assign ca[1] = a_y;
  assign ca[2] = a_z;
  assign ca[3] = a_w;

  // stage 1: products, registered
  logic signed [qau_pkg::ProdBits-1:0] p [16];
  logic signed [qau_pkg::ProdBits-1:0] pm [10];
  logic [1:0] f1;
  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= func;
      p[0] <= a_w * b_x;  p[1] <= a_x * b_w;  p[2] <= a_y * b_z;  p[3] <= a_z * b_y;
      p[4] <= a_w * b_y;  p[5] <= a_x * b_z;  p[6] <= a_y * b_w;  p[7] <= a_z * b_x;
      p[8] <= a_w * b_z;  p[9] <= a_x * b_y;  p[10] <= a_y * b_x; p[11] <= a_z * b_w;
      p[12] <= a_w * b_w; p[13] <= a_x * b_x; p[14] <= a_y * b_y; p[15] <= a_z * b_z;
      pm[0] <= a_x * scale_factor; pm[1] <= a_y * scale_factor;
      pm[2] <= a_z * scale_factor; pm[3] <= a_w * scale_factor;
      pm[4] <= a_x * a_y; pm[5] <= a_x * a_z; pm[6] <= a_y * a_z;
      pm[7] <= a_x * a_w; pm[8] <= a_y * a_w; pm[9] <= a_z * a_w;
    end
  end
  logic signed [qau_pkg::ProdBits-1:0] sq [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0] <= a_x * a_x; sq[1] <= a_y * a_y; sq[2] <= a_z * a_z;
    end
  end

  function automatic qau_pkg::acc_t ex(input logic signed [qau_pkg::ProdBits-1:0] v);
    ex = qau_pkg::acc_t'(v);
  endfunction

  // stage 2: sums
  qau_pkg::acc_t s [9];
  qau_pkg::acc_t s_next [9];
  int sh2;
  logic [1:0] f2;
  qau_pkg::acc_t one;
  assign one = qau_pkg::acc_t'(1) <<< (2 * qau_pkg::FracBits - 1);
  always_comb begin
    for (int i = 0; i < 9; i++) s_next[i] = '0;
    unique case (f1)
      qau_pkg::FUNC_PROD: begin
        s_next[0] = ex(p[0]) + ex(p[1]) + ex(p[2]) - ex(p[3]);
        s_next[1] = ex(p[4]) - ex(p[5]) + ex(p[6]) + ex(p[7]);
        s_next[2] = ex(p[8]) + ex(p[9]) - ex(p[10]) + ex(p[11]);
        s_next[3] = ex(p[12]) - ex(p[13]) - ex(p[14]) - ex(p[15]);
      end
      qau_pkg::FUNC_SCALE: begin
        for (int i = 0; i < 4; i++) s_next[i] = ex(pm[i]);
      end
      qau_pkg::FUNC_MAT: begin
        s_next[0] = one - ex(sq[1]) - ex(sq[2]);
        s_next[1] = ex(pm[4]) - ex(pm[9]);
        s_next[2] = ex(pm[5]) + ex(pm[8]);
        s_next[3] = ex(pm[4]) + ex(pm[9]);
        s_next[4] = one - ex(sq[0]) - ex(sq[2]);
        s_next[5] = ex(pm[6]) - ex(pm[7]);
        s_next[6] = ex(pm[5]) - ex(pm[8]);
        s_next[7] = ex(pm[6]) + ex(pm[7]);
        s_next[8] = one - ex(sq[0]) - ex(sq[1]);
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f2 <= f1;
      s <= s_next;
    end
  end
  assign sh2 = (f2 == qau_pkg::FUNC_MAT) ? qau_pkg::FracBits - 1 : qau_pkg::FracBits;

  // stage 3: round and clamp
  logic [qau_pkg::WordBits:0] rs [9];
  logic [1:0] f3;
  always_ff @(posedge clk) begin
    if (adv) begin
      f3 <= f2;
      for (int i = 0; i < 9; i++) rs[i] <= qau_pkg::round_sat(s[i], sh2);
    end
  end

  // delay line to match the normalize path
  localparam int Dly = Lat - 3;
  logic [qau_pkg::WordBits:0] dl [Dly+1][9];
  logic [1:0]                 df [Dly+1];
  logic [Lat-1:0]             vpipe;
  always_comb begin
    dl[0] = rs;
    df[0] = f3;
  end
  for (genvar k = 0; k < Dly; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (adv) begin
        dl[k+1] <= dl[k];
        df[k+1] <= df[k];
      end
    end
  end

  logic [qau_pkg::WordBits:0] nres [4];
  logic nzero;
  qau_norm_pipe u_norm (
    .clk     (clk),
    .adv     (adv),
    .c_in    (ca),
    .res_out (nres),
    .zero_out(nzero)
  );

  // valid travels with the beat
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (adv) vpipe <= {vpipe[Lat-2:0], in_valid};
  end

  // output register
  logic [qau_pkg::WordBits-1:0] ro [9];
  logic fo;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vpipe[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    logic f;
    if (adv) begin
      f = 1'b0;
      if (df[Dly] == qau_pkg::FUNC_NORM) begin
        for (int i = 0; i < 4; i++) begin
          ro[i] <= nres[i][qau_pkg::WordBits-1:0];
          f = f | nres[i][qau_pkg::WordBits];
        end
        for (int i = 4; i < 9; i++) ro[i] <= '0;
        f = f | nzero;
      end else begin
        for (int i = 0; i < 9; i++) begin
          ro[i] <= dl[Dly][i][qau_pkg::WordBits-1:0];
          f = f | dl[Dly][i][qau_pkg::WordBits];
        end
      end
      fo <= f;
    end
  end
  assign r0 = ro[0]; assign r1 = ro[1]; assign r2 = ro[2];
  assign r3 = ro[3]; assign r4 = ro[4]; assign r5 = ro[5];
  assign r6 = ro[6]; assign r7 = ro[7]; assign r8 = ro[8];
  assign fault = fo;

  // a beat at the end of the valid pipe is not lost when the pipe advances
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    (adv && vpipe[Lat-1]) |=> out_valid) else $error("beat lost at output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fo))) else $error("output changed in stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready low with empty output");
endmodule

// ===== bench/tb_quaternion_arith_unit.sv =====
`timescale 1ns / 1ps

module tb_quaternion_arith_unit;

  typedef struct {
    logic [1:0]     op;
    qau_pkg::word_t a [4];
    qau_pkg::word_t b [4];
    qau_pkg::word_t s;
  } quat_beat_t;

  typedef struct {
    qau_pkg::word_t r [9];
    logic           flt;
  } quat_res_t;

  // Expected results, oldest first, computed on each accepted input beat
  class quat_scoreboard;
    quat_res_t pending [$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    static function longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    static function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    static function longint int_root(longint n);
      longint res;
      longint bt;
      res = 0;
      bt = longint'(1) <<< 62;
      while (bt > n) bt = bt >>> 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n = n - (res + bt);
          res = (res >>> 1) + bt;
        end else begin
          res = res >>> 1;
        end
        bt = bt >>> 2;
      end
      return res;
    endfunction

    function void note_beat(quat_beat_t it);
      longint    ax, ay, az, aw, bx, by, bz, bw, s, n2, len, one;
      longint    v [9];
      quat_res_t e;
      int        i;
      ax = it.a[0]; ay = it.a[1]; az = it.a[2]; aw = it.a[3];
      bx = it.b[0]; by = it.b[1]; bz = it.b[2]; bw = it.b[3];
      s = it.s;
      e.flt = 1'b0;
      for (i = 0; i < 9; i++) v[i] = 0;
      case (it.op)
        qau_pkg::FUNC_PROD: begin
          v[0] = rnd_shift(aw*bx + ax*bw + ay*bz - az*by, qau_pkg::FracBits);
          v[1] = rnd_shift(aw*by - ax*bz + ay*bw + az*bx, qau_pkg::FracBits);
          v[2] = rnd_shift(aw*bz + ax*by - ay*bx + az*bw, qau_pkg::FracBits);
          v[3] = rnd_shift(aw*bw - ax*bx - ay*by - az*bz, qau_pkg::FracBits);
        end
        qau_pkg::FUNC_SCALE: begin
          for (i = 0; i < 4; i++)
            v[i] = rnd_shift(longint'(it.a[i]) * s, qau_pkg::FracBits);
        end
        qau_pkg::FUNC_NORM: begin
          n2 = ax*ax + ay*ay + az*az + aw*aw;
          if (n2 == 0) begin
            e.flt = 1'b1;
          end else begin
            len = int_root(n2);
            for (i = 0; i < 4; i++)
              v[i] = floor_div(2 * (longint'(it.a[i]) <<< qau_pkg::FracBits) + len,
                               2 * len);
          end
        end
        default: begin
          one = longint'(1) <<< (2 * qau_pkg::FracBits - 1);
          v[0] = rnd_shift(one - ay*ay - az*az, qau_pkg::FracBits - 1);
          v[1] = rnd_shift(ax*ay - az*aw, qau_pkg::FracBits - 1);
          v[2] = rnd_shift(ax*az + ay*aw, qau_pkg::FracBits - 1);
          v[3] = rnd_shift(ax*ay + az*aw, qau_pkg::FracBits - 1);
          v[4] = rnd_shift(one - ax*ax - az*az, qau_pkg::FracBits - 1);
          v[5] = rnd_shift(ay*az - ax*aw, qau_pkg::FracBits - 1);
          v[6] = rnd_shift(ax*az - ay*aw, qau_pkg::FracBits - 1);
          v[7] = rnd_shift(ay*az + ax*aw, qau_pkg::FracBits - 1);
          v[8] = rnd_shift(one - ax*ax - ay*ay, qau_pkg::FracBits - 1);
        end
      endcase
      // clamp to the word range
      for (i = 0; i < 9; i++) begin
        if (v[i] > 32767) begin
          v[i] = 32767; e.flt = 1'b1;
        end
        if (v[i] < -32768) begin
          v[i] = -32768; e.flt = 1'b1;
        end
        e.r[i] = qau_pkg::word_t'(v[i]);
      end
      pending.push_back(e);
    endfunction

    function void check_result(quat_res_t got);
      quat_res_t e;
      int        i;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (i = 0; i < 9; i++)
        if (got.r[i] !== e.r[i]) begin
          $display("%0t: r%0d expected %0d actual %0d", $realtime, i, e.r[i], got.r[i]);
          errors++;
        end
      if (got.flt !== e.flt) begin
        $display("%0t: fault expected %0b actual %0b", $realtime, e.flt, got.flt);
        errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     func = qau_pkg::FUNC_PROD;
  qau_pkg::word_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
  qau_pkg::word_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
  qau_pkg::word_t scale_factor = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  qau_pkg::word_t r0, r1, r2, r3, r4, r5, r6, r7, r8;
  logic           fault;

  quat_scoreboard sb = new();
  int  sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;      // no idling on either side
  bit  hold_req = 1'b0;  // receiver holds off for a long stretch

  quaternion_arith_unit dut (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        out_ready = calm ? 1'b1 : ($urandom_range(99) >= 28);
      end
    end
  end

  // result beats
  always @(posedge clk) begin
    quat_res_t got;
    if (!rst && out_valid && out_ready) begin
      got.r[0] = r0; got.r[1] = r1; got.r[2] = r2; got.r[3] = r3; got.r[4] = r4;
      got.r[5] = r5; got.r[6] = r6; got.r[7] = r7; got.r[8] = r8;
      got.flt = fault;
      sb.check_result(got);
    end
  end

  function automatic qau_pkg::word_t pick_word();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return qau_pkg::word_t'($urandom_range(64)) - 16'sd32;
      3: return ($urandom_range(1) ? 16'sh4000 : 16'shc000) +
                qau_pkg::word_t'($urandom_range(15));
      4: return qau_pkg::word_t'($urandom_range(8192)) - 16'sd4096;
      default: return qau_pkg::word_t'($urandom());
    endcase
  endfunction

  // one input beat; valid stays high across back-to-back beats
  task automatic send_beat(quat_beat_t it);
    if (!calm)
      while ($urandom_range(99) < 28) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    func = it.op;
    a_x = it.a[0]; a_y = it.a[1]; a_z = it.a[2]; a_w = it.a[3];
    b_x = it.b[0]; b_y = it.b[1]; b_z = it.b[2]; b_w = it.b[3];
    scale_factor = it.s;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_fill(logic [1:0] op, qau_pkg::word_t av, qau_pkg::word_t bv,
                           qau_pkg::word_t sv);
    quat_beat_t it;
    it.op = op;
    for (int i = 0; i < 4; i++) begin
      it.a[i] = av; it.b[i] = bv;
    end
    it.s = sv;
    send_beat(it);
  endtask

  initial begin
    quat_beat_t it;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, each operation, zero length, identity
    send_fill(qau_pkg::FUNC_PROD, 16'sh7fff, 16'sh7fff, 0);
    send_fill(qau_pkg::FUNC_PROD, 16'sh8000, 16'sh8000, 0);
    send_fill(qau_pkg::FUNC_PROD, 16'sh8000, 16'sh7fff, 0);
    send_fill(qau_pkg::FUNC_SCALE, 16'sh7fff, 0, 16'sh7fff);
    send_fill(qau_pkg::FUNC_SCALE, 16'sh8000, 0, 16'sh8000);
    send_fill(qau_pkg::FUNC_SCALE, 16'sh4000, 0, 16'shc000);
    send_fill(qau_pkg::FUNC_NORM, 0, 0, 0);
    send_fill(qau_pkg::FUNC_NORM, 16'sh8000, 0, 0);
    send_fill(qau_pkg::FUNC_NORM, 16'sh7fff, 0, 0);
    send_fill(qau_pkg::FUNC_NORM, 16'sd1, 0, 0);
    send_fill(qau_pkg::FUNC_MAT, 0, 0, 0);
    send_fill(qau_pkg::FUNC_MAT, 16'sh8000, 0, 0);
    send_fill(qau_pkg::FUNC_MAT, 16'sh7fff, 0, 0);
    send_fill(qau_pkg::FUNC_MAT, 16'sh2000, 0, 0);
    it.op = qau_pkg::FUNC_MAT;
    it.a[0] = 0; it.a[1] = 0; it.a[2] = 0; it.a[3] = 16'sh4000;
    it.b = it.a; it.s = 0;
    send_beat(it);
    it.op = qau_pkg::FUNC_PROD;
    send_beat(it);
    it.op = qau_pkg::FUNC_NORM; it.a[3] = -16'sd1;
    send_beat(it);

    // random beats, with a calm stretch and a long receiver hold-off
    for (int n = 0; n < 1800; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 1000) hold_req = 1'b1;
      it.op = 2'($urandom_range(3));
      for (int i = 0; i < 4; i++) begin
        it.a[i] = pick_word(); it.b[i] = pick_word();
      end
      it.s = pick_word();
      if (it.op == qau_pkg::FUNC_NORM && $urandom_range(19) == 0)
        for (int i = 0; i < 4; i++) it.a[i] = 0;
      send_beat(it);
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/qau_pkg.sv
sv/qau_sqrt_stage.sv
sv/qau_div_stage.sv
sv/qau_norm_pipe.sv
sv/quaternion_arith_unit.sv
bench/tb_quaternion_arith_unit.sv
